[rtl/core/jrq_pkg.sv]
// jrq_pkg: shared types and codes of the job ring queue.
// No dependencies; used by jrq_ctrl and job_ring_queue_top.
`default_nettype none

package jrq_pkg;

    localparam int FIELD_W  = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [KIND_W-1:0] KIND_TAKE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GIVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                take_ok;
        logic                dropped;
        logic                wr_en;
        logic [COUNT_W-1:0]  fill;
        logic [COUNT_W-1:0]  free;
    } t_ctrl_res;

endpackage

`default_nettype wire

[rtl/core/jrq_store.sv]
// jrq_store: slot memory, one write port and one registered read port.
// No package dependencies.
`default_nettype none

module jrq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/jrq_ctrl.sv]
// jrq_ctrl: capacity register, ring pointers, entry count and per-op decision.
// Depends on jrq_pkg.
`default_nettype none

module jrq_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_step,
    input  wire logic [jrq_pkg::KIND_W-1:0]        i_kind,
    input  wire logic                              i_cfg_wr,
    input  wire logic [jrq_pkg::CAP_W-1:0]         i_cfg_data,
    output jrq_pkg::t_ctrl_res                     o_res,
    output logic      [$clog2(DEPTH)-1:0]          o_wr_ptr,
    output logic      [$clog2(DEPTH)-1:0]          o_rd_ptr,
    output logic      [jrq_pkg::CAP_W-1:0]         o_cap
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int AW    = ((PTR_W > jrq_pkg::CAP_W) ? PTR_W : jrq_pkg::CAP_W) + 1;
    localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

    logic [PTR_W-1:0]            r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]            r_wr_ptr, n_wr_ptr;
    logic [jrq_pkg::COUNT_W-1:0] r_count,  n_count;
    logic [jrq_pkg::CAP_W-1:0]   r_cap,    n_cap;
    logic [PTR_W-1:0]            rd_next, wr_next;
    logic [AW-1:0]               rd_inc, wr_inc;
    logic                        full;

    always_comb begin
        rd_inc  = AW'(r_rd_ptr) + AW'(1);
        wr_inc  = AW'(r_wr_ptr) + AW'(1);
        rd_next = (rd_inc < AW'(r_cap)) ? PTR_W'(rd_inc) : '0;
        wr_next = (wr_inc < AW'(r_cap)) ? PTR_W'(wr_inc) : '0;
        full    = (r_count >= jrq_pkg::COUNT_W'(r_cap));
    end

    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = jrq_pkg::CAP_W'(1);
        end else if (AW'(i_cfg_data) > AW'(DEPTH)) begin
            n_cap = jrq_pkg::CAP_W'(DEPTH);
        end else begin
            n_cap = i_cfg_data;
        end
    end

    always_comb begin
        n_rd_ptr        = r_rd_ptr;
        n_wr_ptr        = r_wr_ptr;
        n_count         = r_count;
        o_res.status    = jrq_pkg::STATUS_OK;
        o_res.take_ok   = 1'b0;
        o_res.dropped   = 1'b0;
        o_res.wr_en     = 1'b0;
        case (i_kind)
            jrq_pkg::KIND_TAKE: begin
                if (r_count == '0) begin
                    o_res.status = jrq_pkg::STATUS_EMPTY;
                end else begin
                    o_res.take_ok = 1'b1;
                    n_rd_ptr      = rd_next;
                    n_count       = r_count - 1'b1;
                end
            end
            jrq_pkg::KIND_GIVE: begin
                if (full) begin
                    o_res.status = jrq_pkg::STATUS_FULL;
                end else begin
                    o_res.wr_en = 1'b1;
                    n_wr_ptr    = wr_next;
                    n_count     = r_count + 1'b1;
                end
            end
            jrq_pkg::KIND_PUSH: begin
                o_res.wr_en = 1'b1;
                n_wr_ptr    = wr_next;
                if (full) begin
                    o_res.dropped = 1'b1;
                    n_rd_ptr      = rd_next;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_res.fill = n_count;
        o_res.free = jrq_pkg::COUNT_W'(r_cap) - n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_cap    <= jrq_pkg::CAP_W'(CAP_RST);
        end else if (i_cfg_wr) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_cap    <= n_cap;
        end else if (i_step) begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    assign o_wr_ptr = r_wr_ptr;
    assign o_rd_ptr = r_rd_ptr;
    assign o_cap    = r_cap;

endmodule

`default_nettype wire

[rtl/core/job_ring_queue_top.sv]
// job_ring_queue_top: ring FIFO of job handles with APB capacity register.
// Depends on jrq_pkg, jrq_ctrl and jrq_store.
//
//   channel | handshake                 | payload
//   in      | i_in_valid / o_in_ready   | i_kind, i_job_handle
//   out     | o_out_valid / i_out_ready | o_status, o_taken_handle, o_dropped_oldest,
//           |                           | o_fill_count, o_free_space
//   cfg     | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// One operation per cycle unless the output stalls: input register, decision plus slot
// access, result register; the result is registered once the output is not stalled.
// The slot memory read is registered and lands in the result stage.
// A stalled output holds the result; the input register still takes one more transaction.
// Synchronous reset clears pointers, count and valids; capacity returns to min(DEPTH, 16).
`default_nettype none

module job_ring_queue_top #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [jrq_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [jrq_pkg::FIELD_W-1:0]    i_job_handle,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [jrq_pkg::STATUS_W-1:0]   o_status,
    output logic      [jrq_pkg::FIELD_W-1:0]    o_taken_handle,
    output logic                                o_dropped_oldest,
    output logic      [jrq_pkg::COUNT_W-1:0]    o_fill_count,
    output logic      [jrq_pkg::COUNT_W-1:0]    o_free_space,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [jrq_pkg::APB_AW-1:0]     paddr,
    input  wire logic [jrq_pkg::APB_DW-1:0]     pwdata,
    output logic      [jrq_pkg::APB_DW-1:0]     prdata,
    output logic                                pready
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int KEEP_W = (HANDLE_BITS < jrq_pkg::FIELD_W) ? HANDLE_BITS : jrq_pkg::FIELD_W;

    logic                            r_in_v;
    logic [jrq_pkg::KIND_W-1:0]      r_kind;
    logic [KEEP_W-1:0]               r_handle;
    logic                            r_out_v;
    logic [jrq_pkg::STATUS_W-1:0]    r_status;
    logic                            r_take_ok;
    logic                            r_dropped;
    logic [jrq_pkg::COUNT_W-1:0]     r_fill;
    logic [jrq_pkg::COUNT_W-1:0]     r_free;
    logic                            step;
    logic                            cfg_wr;
    jrq_pkg::t_ctrl_res              res;
    logic [PTR_W-1:0]                wr_ptr, rd_ptr;
    logic [jrq_pkg::CAP_W-1:0]       cap;
    logic [KEEP_W-1:0]               rd_data;

    assign step       = r_in_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_in_v || step;
    assign cfg_wr     = psel && penable && pwrite && pready
                        && (paddr[jrq_pkg::APB_AW-1] == jrq_pkg::REG_CAPACITY);
    assign pready     = 1'b1;
    assign prdata     = jrq_pkg::APB_DW'(cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind   <= i_kind;
            r_handle <= KEEP_W'(i_job_handle);
        end
    end

    jrq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_kind     (r_kind),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (pwdata[jrq_pkg::CAP_W-1:0]),
        .o_res      (res),
        .o_wr_ptr   (wr_ptr),
        .o_rd_ptr   (rd_ptr),
        .o_cap      (cap)
    );

    jrq_store #(
        .DEPTH (DEPTH),
        .WIDTH (KEEP_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (step && res.wr_en),
        .i_wr_addr (wr_ptr),
        .i_wr_data (r_handle),
        .i_rd_en   (step),
        .i_rd_addr (rd_ptr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (step) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status  <= res.status;
            r_take_ok <= res.take_ok;
            r_dropped <= res.dropped;
            r_fill    <= res.fill;
            r_free    <= res.free;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_status         = r_status;
    assign o_taken_handle   = r_take_ok ? jrq_pkg::FIELD_W'(rd_data) : '0;
    assign o_dropped_oldest = r_dropped;
    assign o_fill_count     = r_fill;
    assign o_free_space     = r_free;

endmodule

`default_nettype wire
